// File: rtl/bahc_pkg.sv
// Shared constants, transaction types and the seed fold function for the hash combiner.
package bahc_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned CountW = 4;
    localparam int unsigned RestW  = 24;

    localparam logic [WordW-1:0]  GoldenAdd = 64'h0000_0000_9e37_79b9;
    localparam logic [CountW-1:0] FullCount = 4'd8;

    // Tail bytes left after the first fold of a last word
    typedef struct packed {
        logic [WordW-1:0] seed;
        logic [RestW-1:0] rest;
        logic [1:0]       cnt;
    } t_tail;

    // Single byte left after the 16-bit fold
    typedef struct packed {
        logic [WordW-1:0] seed;
        logic [7:0]       rest;
        logic             take;
    } t_last;

    // seed ^ (piece + golden + (seed << 6) + (seed >> 2)), modulo 2^64
    function automatic logic [WordW-1:0] fold(input logic [WordW-1:0] seed,
                                              input logic [WordW-1:0] piece);
        logic [WordW-1:0] sum;
        sum = piece + GoldenAdd + (seed << 6) + (seed >> 2);
        return seed ^ sum;
    endfunction

endpackage

// File: rtl/bahc_seed_stage.sv
// Input register, running seed loop and the first fold of each word.
module bahc_seed_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bahc_pkg::WordW-1:0]    i_data_word,
    input  logic [bahc_pkg::CountW-1:0]   i_byte_count,
    input  logic                          i_last_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output bahc_pkg::t_tail               o_tail
);

    logic                        r_valid;
    logic [bahc_pkg::WordW-1:0]  r_word;
    logic [bahc_pkg::CountW-1:0] r_count;
    logic                        r_last;
    logic [bahc_pkg::WordW-1:0]  r_seed;

    logic                        consume;
    logic                        load;
    logic                        full;
    logic [bahc_pkg::WordW-1:0]  n_seed;
    bahc_pkg::t_tail             n_tail;

    // A non-last word only updates the seed; a last word needs room downstream
    assign consume = r_valid && (!r_last || !i_stall);
    assign load    = !r_valid || consume;
    assign o_stall = !load;

    // Fold the full word, or the 32-bit piece of a short last word
    assign full = !r_last || (r_count >= bahc_pkg::FullCount);

    always_comb begin
        n_seed      = r_seed;
        n_tail.rest = r_word[bahc_pkg::RestW-1:0];
        n_tail.cnt  = r_count[1:0];
        if (full) begin
            n_seed     = bahc_pkg::fold(r_seed, r_word);
            n_tail.cnt = 2'b00;
        end else if (r_count[2]) begin
            n_seed      = bahc_pkg::fold(r_seed, {32'd0, r_word[31:0]});
            n_tail.rest = r_word[32 +: bahc_pkg::RestW];
        end
        n_tail.seed = n_seed;
    end

    assign o_valid = r_valid && r_last;
    assign o_tail  = n_tail;

    // Hold the input transaction and the running seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seed  <= '0;
        end else begin
            if (load) begin
                r_valid <= i_valid;
            end
            if (consume) begin
                r_seed <= r_last ? '0 : n_seed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= i_data_word;
            r_count <= i_byte_count;
            r_last  <= i_last_word;
        end
    end

endmodule

// File: rtl/bahc_half_stage.sv
// Tail stage that folds the 16-bit piece of a short last word.
module bahc_half_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bahc_pkg::t_tail i_tail,
    output logic            o_valid,
    input  logic            i_stall,
    output bahc_pkg::t_last o_last
);

    logic            r_valid;
    bahc_pkg::t_last r_last;
    bahc_pkg::t_last n_last;

    assign o_stall = r_valid && i_stall;

    // Fold two bytes where present, then pick the byte that remains
    always_comb begin
        n_last.seed = i_tail.seed;
        n_last.rest = i_tail.rest[7:0];
        n_last.take = i_tail.cnt[0];
        if (i_tail.cnt[1]) begin
            n_last.seed = bahc_pkg::fold(i_tail.seed, {48'd0, i_tail.rest[15:0]});
            n_last.rest = i_tail.rest[23:16];
        end
    end

    // Advance when the next stage has room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule

// File: rtl/bahc_out_stage.sv
// Final tail fold of one byte and the result register.
module bahc_out_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  bahc_pkg::t_last            i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bahc_pkg::WordW-1:0] o_hash_value
);

    logic                       r_valid;
    logic [bahc_pkg::WordW-1:0] r_hash;
    logic [bahc_pkg::WordW-1:0] n_hash;

    assign o_stall = r_valid && i_stall;

    // Fold the last byte where present
    assign n_hash = i_last.take ? bahc_pkg::fold(i_last.seed, {56'd0, i_last.rest})
                                : i_last.seed;

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_hash <= n_hash;
        end
    end

    assign o_valid      = r_valid;
    assign o_hash_value = r_hash;

endmodule

// File: rtl/byte_array_hash_combine.sv
// Top level of the byte array hash combiner: seed loop and two tail fold stages.
// Throughput: one word per cycle while o_stall is low; the running seed loop folds one piece per cycle.
// After its transaction is accepted into the input register, the hash of a last word
// is registered in the half stage and then in the result register of the out stage.
// Reset (synchronous, active low) clears the running seed and all valid flags.
module byte_array_hash_combine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bahc_pkg::WordW-1:0]    i_data_word,
    input  logic [bahc_pkg::CountW-1:0]   i_byte_count,
    input  logic                          i_last_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bahc_pkg::WordW-1:0]    o_hash_value
);

    logic            seed_valid;
    logic            half_stall;
    bahc_pkg::t_tail seed_tail;
    logic            half_valid;
    logic            out_stall;
    bahc_pkg::t_last half_last;

    // Seed loop and first fold
    bahc_seed_stage u_seed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_valid      (seed_valid),
        .i_stall      (half_stall),
        .o_tail       (seed_tail)
    );

    // 16-bit tail piece
    bahc_half_stage u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seed_valid),
        .o_stall (half_stall),
        .i_tail  (seed_tail),
        .o_valid (half_valid),
        .i_stall (out_stall),
        .o_last  (half_last)
    );

    // 8-bit tail piece and result register
    bahc_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (half_valid),
        .o_stall      (out_stall),
        .i_last       (half_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule
